// File: rtl/core/sit_pkg.sv
package sit_pkg;

    localparam int CAPACITY = 64;
    localparam int CNT_W    = $clog2(CAPACITY + 1);
    localparam int IDX_W    = 6;
    localparam int FILL_W   = 7;
    localparam int GRP_SZ   = 8;
    localparam int SUB_W    = $clog2(GRP_SZ);
    localparam int NGROUP   = (CAPACITY + GRP_SZ - 1) / GRP_SZ;

    typedef enum logic {
        OP_INSERT = 1'b0,
        OP_READ   = 1'b1
    } t_op;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } t_status;

    typedef struct packed {
        logic        [7:0]  age;
        logic        [31:0] salary;
        logic        [15:0] tag;
        logic signed [31:0] value;
    } t_entry;

    // cell control from the insert decision
    typedef struct packed {
        logic load_new;
        logic load_left;
    } t_cell_ctl;

endpackage

// File: rtl/core/sit_cell.sv
module sit_cell (
    input  logic              i_clk,
    input  sit_pkg::t_cell_ctl i_ctl,
    input  sit_pkg::t_entry   i_new,
    input  sit_pkg::t_entry   i_left,
    output logic              o_above,
    output sit_pkg::t_entry   o_entry
);
    import sit_pkg::*;

    t_entry r_entry;

    // stored key strictly greater than the incoming key
    assign o_above = (r_entry.age != i_new.age) ? (r_entry.age > i_new.age)
                                                : (r_entry.salary > i_new.salary);
    assign o_entry = r_entry;

    always_ff @(posedge i_clk) begin
        if (i_ctl.load_new) begin
            r_entry <= i_new;
        end else if (i_ctl.load_left) begin
            r_entry <= i_left;
        end
    end

endmodule

// File: rtl/core/sit_read_tree.sv
module sit_read_tree (
    input  logic                       i_clk,
    input  logic [sit_pkg::IDX_W-1:0]  i_idx,
    input  sit_pkg::t_entry            i_cells [sit_pkg::CAPACITY],
    output sit_pkg::t_entry            o_entry
);
    import sit_pkg::*;

    t_entry r_grp [NGROUP];
    t_entry n_grp [NGROUP];

    // first level: one entry out of each group of eight
    always_comb begin
        for (int g = 0; g < NGROUP; g++) begin
            n_grp[g] = '0;
            for (int j = 0; j < GRP_SZ; j++) begin
                if ((g * GRP_SZ + j) < CAPACITY) begin
                    if (i_idx[SUB_W-1:0] == SUB_W'(j)) begin
                        n_grp[g] = i_cells[g * GRP_SZ + j];
                    end
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int g = 0; g < NGROUP; g++) begin
            r_grp[g] <= n_grp[g];
        end
    end

    // second level: pick the group
    always_comb begin
        o_entry = '0;
        for (int g = 0; g < NGROUP; g++) begin
            if (int'(i_idx[IDX_W-1:SUB_W]) == g) begin
                o_entry = r_grp[g];
            end
        end
    end

endmodule

// File: rtl/core/sorted_insert_table.sv
// channel  | direction | handshake                   | fields
// ---------+-----------+-----------------------------+--------------------------------------
// command  | in        | start high, busy low        | operation age salary tag value index
// result   | out       | o_valid for one cycle       | status out_age out_salary out_tag
//          |           |                             | out_value fill
//
// an insert beat updates the cell row at its accept edge; its result shows in the next
// cycle and busy stays low, so inserts follow one per cycle
// a read beat holds busy high through S_GRP and S_OUT while the staged read tree
// (eight-way per group, then group select) walks to the addressed cell
// synchronous active-low reset clears the fill count and control; cell contents are
// left as they are, entries at or above the fill count are never read
// the receiver cannot stall: each result is on the ports for exactly one cycle
module sorted_insert_table (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    input  logic                i_operation,
    input  logic [7:0]          i_age,
    input  logic [31:0]         i_salary,
    input  logic [15:0]         i_tag,
    input  logic signed [31:0]  i_value,
    input  logic [5:0]          i_index,
    output logic                busy,
    output logic                o_valid,
    output logic [1:0]          o_status,
    output logic [7:0]          o_out_age,
    output logic [31:0]         o_out_salary,
    output logic [15:0]         o_out_tag,
    output logic signed [31:0]  o_out_value,
    output logic [6:0]          o_fill
);
    import sit_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_GRP,
        S_OUT
    } t_state;

    t_state           r_state;
    logic [CNT_W-1:0] r_count;
    logic [IDX_W-1:0] r_idx;
    logic             r_bad;

    t_entry    new_entry;
    t_entry    cell_q    [CAPACITY];
    logic      above     [CAPACITY];
    logic      past_pos  [CAPACITY];
    t_cell_ctl cell_ctl  [CAPACITY];
    t_entry    rd_entry;

    logic accept;
    logic do_insert;
    logic full;
    logic [CNT_W+FILL_W-1:0] fill_wide;

    assign new_entry = '{age: i_age, salary: i_salary, tag: i_tag, value: i_value};
    assign busy      = (r_state != S_IDLE);
    assign accept    = start && !busy;
    assign full      = (r_count == CNT_W'(CAPACITY));
    assign do_insert = accept && (t_op'(i_operation) == OP_INSERT) && !full;

    // a cell is at or past the insert point when its key is greater or it is empty;
    // the point moves right monotonically since the row is sorted
    always_comb begin
        for (int i = 0; i < CAPACITY; i++) begin
            past_pos[i] = above[i] || (r_count <= CNT_W'(i));
        end
        for (int i = 0; i < CAPACITY; i++) begin
            if (i == 0) begin
                cell_ctl[i].load_new  = do_insert && past_pos[i];
                cell_ctl[i].load_left = 1'b0;
            end else begin
                cell_ctl[i].load_new  = do_insert && past_pos[i] && !past_pos[i-1];
                cell_ctl[i].load_left = do_insert && past_pos[i-1];
            end
        end
    end

    for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
        if (i == 0) begin : g_head
            sit_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[i]),
                .i_new   (new_entry),
                .i_left  (new_entry),
                .o_above (above[i]),
                .o_entry (cell_q[i])
            );
        end else begin : g_body
            sit_cell u_cell (
                .i_clk   (i_clk),
                .i_ctl   (cell_ctl[i]),
                .i_new   (new_entry),
                .i_left  (cell_q[i-1]),
                .o_above (above[i]),
                .o_entry (cell_q[i])
            );
        end
    end

    sit_read_tree u_read (
        .i_clk   (i_clk),
        .i_idx   (r_idx),
        .i_cells (cell_q),
        .o_entry (rd_entry)
    );

    // fill is the count masked to the field width
    assign fill_wide = {{FILL_W{1'b0}}, r_count};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_count <= '0;
            o_valid <= 1'b0;
        end else begin
            o_valid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (accept) begin
                        if (t_op'(i_operation) == OP_INSERT) begin
                            // insert beat: answer in the next cycle
                            o_valid      <= 1'b1;
                            o_out_age    <= '0;
                            o_out_salary <= '0;
                            o_out_tag    <= '0;
                            o_out_value  <= '0;
                            if (full) begin
                                o_status <= ST_FULL;
                                o_fill   <= fill_wide[FILL_W-1:0];
                            end else begin
                                o_status <= ST_OK;
                                r_count  <= r_count + 1'b1;
                                o_fill   <= FILL_W'(fill_wide + 1'b1);
                            end
                        end else begin
                            r_idx   <= i_index;
                            r_bad   <= ({{CNT_W{1'b0}}, i_index} >=
                                        {{IDX_W{1'b0}}, r_count});
                            r_state <= S_GRP;
                        end
                    end
                end
                S_GRP: begin
                    r_state <= S_OUT;
                end
                S_OUT: begin
                    o_valid <= 1'b1;
                    o_fill  <= fill_wide[FILL_W-1:0];
                    if (r_bad) begin
                        o_status     <= ST_RANGE;
                        o_out_age    <= '0;
                        o_out_salary <= '0;
                        o_out_tag    <= '0;
                        o_out_value  <= '0;
                    end else begin
                        o_status     <= ST_OK;
                        o_out_age    <= rd_entry.age;
                        o_out_salary <= rd_entry.salary;
                        o_out_tag    <= rd_entry.tag;
                        o_out_value  <= rd_entry.value;
                    end
                    r_state <= S_IDLE;
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule
